[hw/rtl/tlr_pkg.sv]
// Shared types and constants for the thick line rasterizer.
package tlr_pkg;

   localparam int COORD_W = 6;
   localparam int DEC_W   = 10;
   localparam int WIDTH_W = 4;
   localparam int SPAN_W  = 3;

   localparam logic [WIDTH_W-1:0] STROKE_WIDTH_RESET = WIDTH_W'(1);

   typedef enum logic [1:0] {
      OCT_X_RISE = 2'd0,
      OCT_Y_RISE = 2'd1,
      OCT_X_FALL = 2'd2,
      OCT_Y_FALL = 2'd3
   } tlr_octant_type;

   typedef struct packed {
      logic [COORD_W-1:0] x_start;
      logic [COORD_W-1:0] y_start;
      logic [COORD_W-1:0] x_end;
      logic [COORD_W-1:0] y_end;
   } tlr_req_type;

   typedef struct packed {
      logic [COORD_W-1:0] pixel_x;
      logic [COORD_W-1:0] pixel_y;
      logic               spread_along_y;
      logic [SPAN_W-1:0]  half_span;
      logic               last_pixel;
   } tlr_rsp_type;

   typedef struct packed {
      tlr_octant_type     octant;
      logic [COORD_W-1:0] start_x;
      logic [COORD_W-1:0] start_y;
      logic [COORD_W-1:0] stop_coord;
      logic signed [DEC_W-1:0] decision;
      logic signed [DEC_W-1:0] inc_straight;
      logic signed [DEC_W-1:0] inc_diagonal;
   } tlr_cmd_type;

endpackage

[hw/rtl/tlr_front.sv]
// Request front end: clamps endpoints, picks the octant case, orders endpoints, sets up the walk.
module tlr_front #(
   parameter int GRID_SIZE = 64
) (
   input  logic                req_valid,
   output logic                req_ready,
   input  tlr_pkg::tlr_req_type req_data,
   output logic                cmd_valid,
   input  logic                cmd_ready,
   output tlr_pkg::tlr_cmd_type cmd_data
);
   import tlr_pkg::*;

   localparam logic [COORD_W-1:0] GRID_MAX = COORD_W'(GRID_SIZE - 1);

   function automatic logic [COORD_W-1:0] clamp_coord(input logic [COORD_W-1:0] v);
      return (v > GRID_MAX) ? GRID_MAX : v;
   endfunction

   logic [COORD_W-1:0]        ax, ay, bx, by;
   logic signed [COORD_W:0]   dx, dy, odx, ody;
   logic [COORD_W-1:0]        adx, ady;
   logic                      positive, xmajor, swap;
   tlr_octant_type            octant;
   logic signed [DEC_W-1:0]   wdx, wdy;

   assign req_ready = cmd_ready;
   assign cmd_valid = req_valid;

   always_comb begin
      ax = clamp_coord(req_data.x_start);
      ay = clamp_coord(req_data.y_start);
      bx = clamp_coord(req_data.x_end);
      by = clamp_coord(req_data.y_end);
      dx = signed'({1'b0, bx}) - signed'({1'b0, ax});
      dy = signed'({1'b0, by}) - signed'({1'b0, ay});
      adx = dx[COORD_W] ? COORD_W'(-dx) : dx[COORD_W-1:0];
      ady = dy[COORD_W] ? COORD_W'(-dy) : dy[COORD_W-1:0];
      positive = (dy > 0 && dx >= 0) || (dy < 0 && dx < 0);
      xmajor = ady < adx;
      if (positive) begin
         octant = xmajor ? OCT_X_RISE : OCT_Y_RISE;
      end else begin
         octant = xmajor ? OCT_X_FALL : OCT_Y_FALL;
      end
      unique case (octant)
         OCT_X_RISE, OCT_X_FALL: swap = ax > bx;
         OCT_Y_RISE:             swap = ay > by;
         OCT_Y_FALL:             swap = ay <= by;
         default:                swap = 1'b0;
      endcase
      odx = swap ? -dx : dx;
      ody = swap ? -dy : dy;
      wdx = {{(DEC_W-COORD_W-1){odx[COORD_W]}}, odx};
      wdy = {{(DEC_W-COORD_W-1){ody[COORD_W]}}, ody};

      cmd_data.octant  = octant;
      cmd_data.start_x = swap ? bx : ax;
      cmd_data.start_y = swap ? by : ay;
      unique case (octant)
         OCT_X_RISE: begin
            cmd_data.decision     = (wdy <<< 1) - wdx;
            cmd_data.inc_straight = wdy <<< 1;
            cmd_data.inc_diagonal = (wdy - wdx) <<< 1;
            cmd_data.stop_coord   = swap ? ax : bx;
         end
         OCT_Y_RISE: begin
            cmd_data.decision     = wdy - (wdx <<< 1);
            cmd_data.inc_straight = -(wdx <<< 1);
            cmd_data.inc_diagonal = (wdy - wdx) <<< 1;
            cmd_data.stop_coord   = swap ? ay : by;
         end
         OCT_X_FALL: begin
            cmd_data.decision     = (wdy <<< 1) + wdx;
            cmd_data.inc_straight = wdy <<< 1;
            cmd_data.inc_diagonal = (wdy + wdx) <<< 1;
            cmd_data.stop_coord   = swap ? ax : bx;
         end
         default: begin
            cmd_data.decision     = wdy + (wdx <<< 1);
            cmd_data.inc_straight = wdx <<< 1;
            cmd_data.inc_diagonal = (wdy + wdx) <<< 1;
            cmd_data.stop_coord   = swap ? ay : by;
         end
      endcase
   end

endmodule

[hw/rtl/tlr_queue.sv]
// Two-entry command queue between the front end and the line walker.
module tlr_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   output logic                 push_ready,
   input  tlr_pkg::tlr_cmd_type push_data,
   output logic                 pop_valid,
   input  logic                 pop_ready,
   output tlr_pkg::tlr_cmd_type pop_data
);
   import tlr_pkg::*;

   tlr_cmd_type entry_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        do_push, do_pop;

   assign push_ready = count_ff != 2'd2;
   assign pop_valid  = count_ff != 2'd0;
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[hw/rtl/tlr_back.sv]
// Line walker: steps the midpoint decision; one centre pixel per cycle when not stalled.
module tlr_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 cmd_valid,
   output logic                 cmd_ready,
   input  tlr_pkg::tlr_cmd_type cmd_data,
   input  logic [tlr_pkg::SPAN_W-1:0] half_span,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output tlr_pkg::tlr_rsp_type rsp_data
);
   import tlr_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_WALK = 2'b10
   } tlr_state_type;

   tlr_state_type           state_ff, state_in;
   tlr_octant_type          octant_ff, octant_in;
   logic [COORD_W-1:0]      cur_x_ff, cur_x_in;
   logic [COORD_W-1:0]      cur_y_ff, cur_y_in;
   logic [COORD_W-1:0]      stop_ff, stop_in;
   logic signed [DEC_W-1:0] decision_ff, decision_in;
   logic signed [DEC_W-1:0] inc_straight_ff, inc_straight_in;
   logic signed [DEC_W-1:0] inc_diagonal_ff, inc_diagonal_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   tlr_rsp_type             rsp_data_ff, rsp_data_in;
   logic                    out_free, more, straight, x_major;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign cmd_ready = state_ff == ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      x_major = octant_ff == OCT_X_RISE || octant_ff == OCT_X_FALL;
      unique case (octant_ff)
         OCT_X_RISE: begin
            more     = cur_x_ff < stop_ff;
            straight = decision_ff <= 0;
         end
         OCT_Y_RISE: begin
            more     = cur_y_ff < stop_ff;
            straight = decision_ff > 0;
         end
         OCT_X_FALL: begin
            more     = cur_x_ff < stop_ff;
            straight = decision_ff >= 0;
         end
         default: begin
            more     = cur_y_ff > stop_ff;
            straight = decision_ff < 0;
         end
      endcase
   end

   always_comb begin
      state_in        = state_ff;
      octant_in       = octant_ff;
      cur_x_in        = cur_x_ff;
      cur_y_in        = cur_y_ff;
      stop_in         = stop_ff;
      decision_in     = decision_ff;
      inc_straight_in = inc_straight_ff;
      inc_diagonal_in = inc_diagonal_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_data_in     = rsp_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               octant_in       = cmd_data.octant;
               cur_x_in        = cmd_data.start_x;
               cur_y_in        = cmd_data.start_y;
               stop_in         = cmd_data.stop_coord;
               decision_in     = cmd_data.decision;
               inc_straight_in = cmd_data.inc_straight;
               inc_diagonal_in = cmd_data.inc_diagonal;
               state_in        = ST_WALK;
            end
         end
         ST_WALK: begin
            if (out_free) begin
               rsp_valid_in               = 1'b1;
               rsp_data_in.pixel_x        = cur_x_ff;
               rsp_data_in.pixel_y        = cur_y_ff;
               rsp_data_in.spread_along_y = x_major;
               rsp_data_in.half_span      = half_span;
               rsp_data_in.last_pixel     = !more;
               if (!more) begin
                  state_in = ST_IDLE;
               end else begin
                  decision_in = decision_ff + (straight ? inc_straight_ff : inc_diagonal_ff);
                  unique case (octant_ff)
                     OCT_X_RISE: begin
                        cur_x_in = cur_x_ff + 1'b1;
                        cur_y_in = straight ? cur_y_ff : cur_y_ff + 1'b1;
                     end
                     OCT_Y_RISE: begin
                        cur_y_in = cur_y_ff + 1'b1;
                        cur_x_in = straight ? cur_x_ff : cur_x_ff + 1'b1;
                     end
                     OCT_X_FALL: begin
                        cur_x_in = cur_x_ff + 1'b1;
                        cur_y_in = straight ? cur_y_ff : cur_y_ff - 1'b1;
                     end
                     default: begin
                        cur_y_in = cur_y_ff - 1'b1;
                        cur_x_in = straight ? cur_x_ff : cur_x_ff + 1'b1;
                     end
                  endcase
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      octant_ff       <= octant_in;
      cur_x_ff        <= cur_x_in;
      cur_y_ff        <= cur_y_in;
      stop_ff         <= stop_in;
      decision_ff     <= decision_in;
      inc_straight_ff <= inc_straight_in;
      inc_diagonal_ff <= inc_diagonal_in;
      rsp_data_ff     <= rsp_data_in;
   end

endmodule

[hw/rtl/thick_line_rasterizer.sv]
// Thick line rasterizer top level: stroke width register, front end, command queue, line walker.
//
// Each request carries two endpoints and yields one response per centre pixel of the line, in
// walk order, the final one flagged with last_pixel. The front end clamps, classifies and sets
// up a request in the cycle it is accepted and places it in a two-entry queue, so up to two
// further requests are taken while a line is being drawn. The walker loads a line from the queue
// while idle, then emits one pixel per cycle while rsp_ready is high and returns to idle after
// the last pixel, only then taking the next line. Each response carries stroke_width / 2 as
// its half span; write stroke_width only while no line is in flight.
module thick_line_rasterizer #(
   parameter int GRID_SIZE = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [tlr_pkg::WIDTH_W-1:0]   csr_data,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  tlr_pkg::tlr_req_type          req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output tlr_pkg::tlr_rsp_type          rsp_data
);
   import tlr_pkg::*;

   logic [WIDTH_W-1:0] stroke_width_ff, stroke_width_in;
   logic [SPAN_W-1:0]  half_span;
   logic               push_valid, push_ready, pop_valid, pop_ready;
   tlr_cmd_type        push_data, pop_data;

   assign csr_ready = 1'b1;
   assign half_span = SPAN_W'(stroke_width_ff >> 1);

   always_comb begin
      stroke_width_in = (csr_valid && csr_ready) ? csr_data : stroke_width_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stroke_width_ff <= STROKE_WIDTH_RESET;
      end else begin
         stroke_width_ff <= stroke_width_in;
      end
   end

   tlr_front #(
      .GRID_SIZE (GRID_SIZE)
   ) u_front (
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .cmd_valid (push_valid),
      .cmd_ready (push_ready),
      .cmd_data  (push_data)
   );

   tlr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   tlr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (pop_valid),
      .cmd_ready (pop_ready),
      .cmd_data  (pop_data),
      .half_span (half_span),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
